// ===== rtl/core/b2k_pkg.sv =====
package b2k_pkg;

    localparam int BrightW = 32;
    localparam int FracW   = 16;
    localparam int ExpW    = 5;
    localparam int L2W     = ExpW + FracW;      // signed log2, Q.16
    localparam int DenW    = 24;                // positive denominator always fits
    localparam int NumW    = 40;                // slope_b << 12
    localparam int KelW    = 20;
    localparam int StatW   = 2;
    localparam int AW      = 24;
    localparam int BW      = 28;
    localparam int CfgW    = 28;
    localparam int CfgIdxW = 2;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_OFFSET_A   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SLOPE_B    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_KELVIN = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_MAX_KELVIN = 2'd3;

    // status codes
    localparam logic [StatW-1:0] ST_OK       = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_BRT  = 2'd1;
    localparam logic [StatW-1:0] ST_BAD_DEN  = 2'd2;
    localparam logic [StatW-1:0] ST_RANGE    = 2'd3;

    localparam logic [KelW-1:0] MAX_KELVIN_RST = 20'hFFFFF;

    // per-request sideband flags
    typedef struct packed {
        logic vld;
        logic zero;
        logic dneg;
        logic ovf;
    } side_t;

    // log2 squaring stage
    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [ExpW-1:0]  e;
        logic [31:0]      m;
        logic [FracW-1:0] frac;
    } lg_stage_t;

    // divider stage
    typedef struct packed {
        side_t           side;
        logic [DenW-1:0] d;
        logic [NumW-1:0] rem;
        logic [KelW-1:0] q;
    } dv_stage_t;

endpackage

// ===== rtl/core/b2k_log2.sv =====
module b2k_log2 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic [b2k_pkg::BrightW-1:0]    in_brightness,
    output b2k_pkg::side_t                 out_side,
    output logic signed [b2k_pkg::L2W-1:0] out_l2
);

    localparam int Steps = b2k_pkg::FracW;

    b2k_pkg::lg_stage_t stg_reg  [0:Steps];
    b2k_pkg::lg_stage_t stg_next [0:Steps];

    logic [b2k_pkg::ExpW-1:0] lead;

    // leading one position
    always_comb begin
        lead = '0;
        for (int i = 0; i < b2k_pkg::BrightW; i++) begin
            if (in_brightness[i]) begin
                lead = i[b2k_pkg::ExpW-1:0];
            end
        end
    end

    // normalize into Q1.31
    always_comb begin
        stg_next[0].vld  = in_vld;
        stg_next[0].zero = (in_brightness == '0);
        stg_next[0].e    = lead;
        stg_next[0].m    = in_brightness << (5'd31 - lead);
        stg_next[0].frac = '0;
    end

    // one fraction bit per stage: square, renormalize
    for (genvar k = 1; k <= Steps; k++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] t;
        always_comb begin
            sq = 64'(stg_reg[k-1].m) * 64'(stg_reg[k-1].m);
            t  = sq[63:31];
            stg_next[k].vld  = stg_reg[k-1].vld;
            stg_next[k].zero = stg_reg[k-1].zero;
            stg_next[k].e    = stg_reg[k-1].e;
            stg_next[k].m    = t[32] ? t[32:1] : t[31:0];
            stg_next[k].frac = {stg_reg[k-1].frac[Steps-2:0], t[32]};
        end
    end

    for (genvar k = 0; k <= Steps; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k] <= '0;
            end else if (en) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // integer part e - 16 in five bits is e with the top bit flipped
    assign out_l2   = {~stg_reg[Steps].e[4], stg_reg[Steps].e[3:0], stg_reg[Steps].frac};
    assign out_side = '{vld: stg_reg[Steps].vld, zero: stg_reg[Steps].zero,
                        dneg: 1'b0, ovf: 1'b0};

endmodule

// ===== rtl/core/b2k_div.sv =====
module b2k_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  b2k_pkg::side_t              in_side,
    input  logic [b2k_pkg::DenW-1:0]    in_d,
    input  logic [b2k_pkg::BW-1:0]      slope_b,
    output b2k_pkg::side_t              out_side,
    output logic [b2k_pkg::KelW-1:0]    out_q
);

    localparam int QW  = b2k_pkg::KelW;
    localparam int CmW = b2k_pkg::DenW + QW;

    b2k_pkg::dv_stage_t stg_reg  [0:QW];
    b2k_pkg::dv_stage_t stg_next [0:QW];

    logic [b2k_pkg::NumW-1:0] num;

    // overflow when the quotient needs more than 20 bits
    always_comb begin
        num = {slope_b, 12'd0};
        stg_next[0].side     = in_side;
        stg_next[0].side.ovf = ({{(CmW-b2k_pkg::NumW){1'b0}}, num} >= {in_d, {QW{1'b0}}});
        stg_next[0].d        = in_d;
        stg_next[0].rem      = num;
        stg_next[0].q        = '0;
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [CmW-1:0] dsh;
        logic [CmW-1:0] rx;
        logic           ge;
        always_comb begin
            dsh = {{QW{1'b0}}, stg_reg[j-1].d} << (QW - j);
            rx  = {{(CmW-b2k_pkg::NumW){1'b0}}, stg_reg[j-1].rem};
            ge  = (rx >= dsh);
            stg_next[j].side = stg_reg[j-1].side;
            stg_next[j].d    = stg_reg[j-1].d;
            stg_next[j].rem  = ge ? b2k_pkg::NumW'(rx - dsh) : stg_reg[j-1].rem;
            stg_next[j].q    = {stg_reg[j-1].q[QW-2:0], ge};
        end
    end

    for (genvar k = 0; k <= QW; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k] <= '0;
            end else if (en) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign out_side = stg_reg[QW].side;
    assign out_q    = stg_reg[QW].q;

endmodule

// ===== rtl/core/brightness_to_kelvin.sv =====
// Brightness (Q16.16) to kelvin (Q16.4) by T = B / (A - ln S).
// Pipeline from input request to result: 17 log2 stages (normalize plus
// one squaring multiplier per fraction bit), 2 ln/denominator stages, 21 divider
// stages (overflow check plus one restoring step per quotient bit), 1 output stage.
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
module brightness_to_kelvin (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [b2k_pkg::BrightW-1:0]     s_brightness,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [b2k_pkg::KelW-1:0]        m_kelvin,
    output logic [b2k_pkg::StatW-1:0]       m_status,
    input  logic                            cfg_we,
    input  logic [b2k_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [b2k_pkg::CfgW-1:0]        cfg_data
);

    logic en;

    logic [b2k_pkg::AW-1:0]   offset_a_reg;
    logic [b2k_pkg::BW-1:0]   slope_b_reg;
    logic [b2k_pkg::KelW-1:0] min_kelvin_reg;
    logic [b2k_pkg::KelW-1:0] max_kelvin_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_a_reg   <= '0;
            slope_b_reg    <= '0;
            min_kelvin_reg <= '0;
            max_kelvin_reg <= b2k_pkg::MAX_KELVIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                b2k_pkg::REG_OFFSET_A:   offset_a_reg   <= cfg_data[b2k_pkg::AW-1:0];
                b2k_pkg::REG_SLOPE_B:    slope_b_reg    <= cfg_data[b2k_pkg::BW-1:0];
                b2k_pkg::REG_MIN_KELVIN: min_kelvin_reg <= cfg_data[b2k_pkg::KelW-1:0];
                b2k_pkg::REG_MAX_KELVIN: max_kelvin_reg <= cfg_data[b2k_pkg::KelW-1:0];
                default: ;
            endcase
        end
    end

    // global advance: moves unless a result waits at the output
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // log2
    b2k_pkg::side_t                 lg_side;
    logic signed [b2k_pkg::L2W-1:0] lg_l2;

    b2k_log2 u_log2 (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_vld        (s_valid),
        .in_brightness (s_brightness),
        .out_side      (lg_side),
        .out_l2        (lg_l2)
    );

    // ln stage 1: magnitude times ln2
    b2k_pkg::side_t          ln_side_reg;
    logic                    ln_neg_reg;
    logic [52:0]             ln_prod_reg;
    logic [b2k_pkg::L2W-1:0] mag;

    assign mag = lg_l2[b2k_pkg::L2W-1] ? b2k_pkg::L2W'(-lg_l2) : b2k_pkg::L2W'(lg_l2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ln_side_reg <= '0;
        end else if (en) begin
            ln_side_reg <= lg_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ln_neg_reg  <= lg_l2[b2k_pkg::L2W-1];
            ln_prod_reg <= 53'(mag) * 53'(b2k_pkg::LN2_Q32);
        end
    end

    // ln stage 2: round, restore sign, denominator A - ln S
    logic [52:0]        rnd;
    logic [20:0]        r;
    logic signed [25:0] lnv;
    logic signed [25:0] d;
    b2k_pkg::side_t     dn_side_next;
    b2k_pkg::side_t     dn_side_reg;
    logic [b2k_pkg::DenW-1:0] dn_d_reg;

    always_comb begin
        rnd = ln_prod_reg + 53'h8000_0000;
        r   = rnd[52:32];
        lnv = ln_neg_reg ? -$signed({5'd0, r}) : $signed({5'd0, r});
        d   = 26'($signed(offset_a_reg)) - lnv;
        dn_side_next      = ln_side_reg;
        dn_side_next.dneg = (d <= 26'sd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_side_reg <= '0;
        end else if (en) begin
            dn_side_reg <= dn_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dn_d_reg <= d[b2k_pkg::DenW-1:0];
        end
    end

    // divider
    b2k_pkg::side_t           dv_side;
    logic [b2k_pkg::KelW-1:0] dv_q;

    b2k_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_side  (dn_side_reg),
        .in_d     (dn_d_reg),
        .slope_b  (slope_b_reg),
        .out_side (dv_side),
        .out_q    (dv_q)
    );

    // classify and register the result
    logic [b2k_pkg::StatW-1:0] status_next;
    logic [b2k_pkg::KelW-1:0]  kelvin_next;
    logic [b2k_pkg::StatW-1:0] m_status_reg;
    logic [b2k_pkg::KelW-1:0]  m_kelvin_reg;

    always_comb begin
        kelvin_next = '0;
        priority if (dv_side.zero) begin
            status_next = b2k_pkg::ST_BAD_BRT;
        end else if (dv_side.dneg) begin
            status_next = b2k_pkg::ST_BAD_DEN;
        end else if (dv_side.ovf || dv_q < min_kelvin_reg || dv_q > max_kelvin_reg) begin
            status_next = b2k_pkg::ST_RANGE;
        end else begin
            status_next = b2k_pkg::ST_OK;
            kelvin_next = dv_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= status_next;
            m_kelvin_reg <= kelvin_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_kelvin = m_kelvin_reg;

    // a good result lies inside the programmed window
    a_ok_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == b2k_pkg::ST_OK
            |-> m_kelvin >= min_kelvin_reg && m_kelvin <= max_kelvin_reg)
        else $error("kelvin outside window with good status");

    // any failure reports zero kelvin
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != b2k_pkg::ST_OK |-> m_kelvin == '0)
        else $error("nonzero kelvin on failed request");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kelvin) && $stable(m_status))
        else $error("result changed while stalled");

    // input is refused only while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without a waiting result");

endmodule
